FILE: hdl/gos_pkg.sv
// Shared types and constants of the gradient optimizer step core.
package gos_pkg;

  localparam int STATE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STATE_DEPTH);
  localparam int DATA_W      = 32;
  localparam int IDX_W       = 12;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_SGD  = 2'd0;
  localparam mode_t MODE_MOM  = 2'd1;
  localparam mode_t MODE_RMS  = 2'd2;
  localparam mode_t MODE_ADAM = 2'd3;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_LR   = 3'd1;
  localparam logic [2:0] REG_B1   = 3'd2;
  localparam logic [2:0] REG_B2   = 3'd3;
  localparam logic [2:0] REG_EPS  = 3'd4;

  localparam mode_t       RST_MODE = MODE_ADAM;
  localparam logic [23:0] RST_LR   = 24'd167772;
  localparam logic [23:0] RST_B1   = 24'd15099494;
  localparam logic [23:0] RST_B2   = 24'd16760439;
  localparam logic [28:0] RST_EPS  = 29'd429;

  typedef struct packed {
    logic [IDX_W-1:0]         param_index;
    logic signed [DATA_W-1:0] param_value;
    logic signed [DATA_W-1:0] gradient;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_param;
    logic                     flagged;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]        idx;
    logic signed [DATA_W-1:0] p;
    logic signed [DATA_W-1:0] g;
    logic                     use_first;
    logic                     use_second;
  } cmd_t;

  typedef struct packed {
    mode_t       mode;
    logic [23:0] lr;
    logic [23:0] b1;
    logic [23:0] b2;
    logic [28:0] eps;
  } cfg_t;

endpackage

FILE: hdl/gos_front.sv
// Input queue that accepts items and classifies them by update rule.
module gos_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  gos_pkg::in_item_t in_item,
  input  gos_pkg::mode_t    cfg_mode,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output gos_pkg::cmd_t     cmd_o
);

  gos_pkg::cmd_t q_r [2];
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    cnt_r;
  logic          do_push;
  logic          do_pop;
  gos_pkg::cmd_t cls;

  always_comb begin
    cls.idx        = in_item.param_index[gos_pkg::ADDR_W-1:0];
    cls.p          = in_item.param_value;
    cls.g          = in_item.gradient;
    cls.use_first  = (cfg_mode == gos_pkg::MODE_MOM) || (cfg_mode == gos_pkg::MODE_ADAM);
    cls.use_second = (cfg_mode == gos_pkg::MODE_RMS) || (cfg_mode == gos_pkg::MODE_ADAM);
  end

  assign full        = (cnt_r == 2'd2);
  assign cmd_valid_o = (cnt_r != 2'd0);
  assign cmd_o       = q_r[rp_r];
  assign do_push     = push && !full;
  assign do_pop      = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

FILE: hdl/gos_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module gos_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] rad_r;
  logic [34:0] rem_r;
  logic [31:0] root_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [34:0] rem_sh;
  logic [34:0] trial;

  assign rem_sh = {rem_r[32:0], rad_r[63:62]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign done_o = done_r;
  assign root_o = root_r;

  always_ff @(posedge clk) begin
    if (start_i) begin
      rad_r  <= rad_i;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/gos_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module gos_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start_i,
  input  logic [55:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [55:0] quo_o
);

  logic [55:0] num_r;
  logic [31:0] den_r;
  logic [31:0] rem_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] rem_sh;
  logic        qbit;

  assign rem_sh = {rem_r, num_r[55]};
  assign qbit   = (rem_sh >= {1'b0, den_r});
  assign done_o = done_r;
  assign quo_o  = num_r;

  always_ff @(posedge clk) begin
    if (start_i) begin
      num_r <= num_i;
      den_r <= den_i;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[54:0], qbit};
      rem_r <= qbit ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd55;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/gos_back.sv
// Update sequencer with the moment stores, multipliers, root and divider.
module gos_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gos_pkg::cfg_t        cfg,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  gos_pkg::cmd_t        cmd_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output gos_pkg::out_item_t   res_o
);

  typedef enum logic [8:0] {
    ST_CLR  = 9'b000000001,
    ST_IDLE = 9'b000000010,
    ST_RD   = 9'b000000100,
    ST_MUL  = 9'b000001000,
    ST_SUM  = 9'b000010000,
    ST_PRE  = 9'b000100000,
    ST_SQRT = 9'b001000000,
    ST_DIV  = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_t;

  state_t                      state_r;
  logic [gos_pkg::ADDR_W-1:0]  clr_cnt_r;
  gos_pkg::cmd_t               cmd_r;

  logic signed [31:0] fm_mem [gos_pkg::STATE_DEPTH];
  logic [47:0]        sm_mem [gos_pkg::STATE_DEPTH];
  logic signed [31:0] fm_rd_r;
  logic [47:0]        sm_rd_r;

  logic                       wr_en;
  logic                       fm_we;
  logic                       sm_we;
  logic [gos_pkg::ADDR_W-1:0] wa;
  logic signed [31:0]         fm_wd;
  logic [47:0]                sm_wd;

  logic [31:0]        mag;
  logic [63:0]        mm_r;
  logic signed [56:0] pb_r;
  logic signed [57:0] pc_r;
  logic [47:0]        sh_r;
  logic [47:0]        sl_r;
  logic [48:0]        qh_r;
  logic [48:0]        ql_r;
  logic signed [25:0] c1s;
  logic signed [24:0] b1s;
  logic [24:0]        c2;
  logic [47:0]        gsq;

  logic signed [58:0] vsum;
  logic signed [34:0] vr;
  logic signed [31:0] v_new;
  logic [49:0]        hi;
  logic [49:0]        lo;
  logic [47:0]        s_new;

  logic signed [31:0] x_r;
  logic [47:0]        s_r;
  logic signed [56:0] prod_r;
  logic               dz_r;
  logic [48:0]        rsum;
  logic [47:0]        rcap;
  logic               sqrt_start;
  logic               sqrt_done;
  logic [31:0]        sqrt_root;
  logic               div_start;
  logic               div_done;
  logic [55:0]        div_quo;
  logic [55:0]        prod_mag;

  logic signed [57:0] rnd;
  logic signed [57:0] qs;
  logic signed [57:0] diff;
  logic signed [57:0] sat_hi;
  logic signed [57:0] sat_lo;

  // Moment stores.
  always_ff @(posedge clk) begin
    if (fm_we) begin
      fm_mem[wa] <= fm_wd;
    end
    if (state_r == ST_RD) begin
      fm_rd_r <= fm_mem[cmd_r.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (sm_we) begin
      sm_mem[wa] <= sm_wd;
    end
    if (state_r == ST_RD) begin
      sm_rd_r <= sm_mem[cmd_r.idx];
    end
  end

  assign wr_en = (state_r == ST_SUM);
  assign fm_we = (state_r == ST_CLR) || (wr_en && cmd_r.use_first);
  assign sm_we = (state_r == ST_CLR) || (wr_en && cmd_r.use_second);
  assign wa    = (state_r == ST_CLR) ? clr_cnt_r : cmd_r.idx;
  assign fm_wd = (state_r == ST_CLR) ? 32'sd0 : v_new;
  assign sm_wd = (state_r == ST_CLR) ? 48'd0 : s_new;

  // Arithmetic.
  assign mag = cmd_r.g[31] ? 32'(~cmd_r.g + 32'sd1) : cmd_r.g;
  assign b1s = $signed({1'b0, cfg.b1});
  assign c1s = $signed({1'b0, 25'(25'd16777216 - {1'b0, cfg.b1})});
  assign c2  = 25'd16777216 - {1'b0, cfg.b2};
  assign gsq = 48'((mm_r + 64'd32768) >> 16);

  assign vsum = 59'(pb_r) + 59'(pc_r) + 59'sd8388608;
  assign vr   = 35'(vsum >>> 24);
  always_comb begin
    if (vr > 35'sd2147483647) begin
      v_new = 32'sh7fffffff;
    end else if (vr < -35'sd2147483648) begin
      v_new = 32'sh80000000;
    end else begin
      v_new = vr[31:0];
    end
  end
  assign hi    = 50'(sh_r) + 50'(qh_r);
  assign lo    = 50'(sl_r) + 50'(ql_r);
  assign s_new = 48'(hi + ((lo + 50'd8388608) >> 24));

  assign rsum     = 49'(s_r) + 49'(cfg.eps);
  assign rcap     = rsum[48] ? '1 : rsum[47:0];
  assign prod_mag = prod_r[56] ? 56'(-prod_r) : prod_r[55:0];

  assign sqrt_start = (state_r == ST_PRE) && cmd_r.use_second;
  assign div_start  = (state_r == ST_SQRT) && sqrt_done && (sqrt_root != 32'd0);

  gos_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start_i(sqrt_start),
    .rad_i  ({rcap, 16'd0}),
    .done_o (sqrt_done),
    .root_o (sqrt_root)
  );

  gos_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start_i(div_start),
    .num_i  (prod_mag),
    .den_i  (sqrt_root),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign rnd    = 58'((prod_r + 57'sd8388608) >>> 24);
  assign qs     = x_r[31] ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
  assign sat_hi = 58'sd2147483647;
  assign sat_lo = -58'sd2147483648;

  always_comb begin
    if (cmd_r.use_second) begin
      diff = 58'(cmd_r.p) - qs;
    end else begin
      diff = 58'(cmd_r.p) - rnd;
    end
    if (cmd_r.use_second && dz_r) begin
      res_o.new_param = cmd_r.p;
      res_o.flagged   = 1'b1;
    end else if (diff > sat_hi) begin
      res_o.new_param = 32'sh7fffffff;
      res_o.flagged   = 1'b1;
    end else if (diff < sat_lo) begin
      res_o.new_param = 32'sh80000000;
      res_o.flagged   = 1'b1;
    end else begin
      res_o.new_param = diff[31:0];
      res_o.flagged   = 1'b0;
    end
  end

  assign cmd_ready_o = (state_r == ST_IDLE);
  assign res_valid_o = (state_r == ST_FIN);

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (cmd_ready_o && cmd_valid_i) begin
      cmd_r <= cmd_i;
    end
    if (state_r == ST_RD) begin
      mm_r <= mag * mag;
    end
    if (state_r == ST_MUL) begin
      pb_r <= b1s * fm_rd_r;
      pc_r <= c1s * cmd_r.g;
      sh_r <= cfg.b2 * sm_rd_r[47:24];
      sl_r <= cfg.b2 * sm_rd_r[23:0];
      qh_r <= c2 * gsq[47:24];
      ql_r <= c2 * gsq[23:0];
    end
    if (state_r == ST_SUM) begin
      x_r <= cmd_r.use_first ? v_new : cmd_r.g;
      s_r <= s_new;
    end
    if (state_r == ST_PRE) begin
      prod_r <= $signed({1'b0, cfg.lr}) * x_r;
      dz_r   <= 1'b0;
    end
    if (state_r == ST_SQRT && sqrt_done) begin
      dz_r <= (sqrt_root == 32'd0);
    end
  end

  // Sequencer; after reset it sweeps both stores to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      clr_cnt_r <= '0;
    end else begin
      unique case (state_r)
        ST_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == gos_pkg::ADDR_W'(gos_pkg::STATE_DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid_i) begin
            state_r <= ST_RD;
          end
        end
        ST_RD:  state_r <= ST_MUL;
        ST_MUL: state_r <= ST_SUM;
        ST_SUM: state_r <= ST_PRE;
        ST_PRE: state_r <= cmd_r.use_second ? ST_SQRT : ST_FIN;
        ST_SQRT: begin
          if (sqrt_done) begin
            state_r <= (sqrt_root == 32'd0) ? ST_FIN : ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (res_ready_i) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> state_r == ST_SQRT)
    else $error("root result arrived outside its wait state");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("quotient arrived outside its wait state");

  a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLR |=> state_r == ST_CLR || state_r == ST_IDLE)
    else $error("clearing sweep left early");

endmodule

FILE: hdl/gradient_optimizer_step_core.sv
// Gradient optimizer step core: registers, front queue, back end and result queue.
// After reset both moment stores are swept to zero; items wait in the front queue.
// Gradient descent and momentum results pass the back end's read, multiply, sum and prepare states.
// Rmsprop and Adam then wait for the 32-step square root and, unless the root is zero,
// the 56-step divider; the back end works on one transaction at a time.
// Reset (rst_n, synchronous) restores register defaults and empties both queues.
module gradient_optimizer_step_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  gos_pkg::in_item_t   in_item,
  output logic                empty,
  input  logic                pop,
  output gos_pkg::out_item_t  out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  gos_pkg::cfg_t      cfg_r;
  logic               cmd_valid;
  logic               cmd_ready;
  gos_pkg::cmd_t      cmd;
  logic               res_valid;
  logic               res_ready;
  gos_pkg::out_item_t res;
  gos_pkg::out_item_t oq_r [2];
  logic               owp_r;
  logic               orp_r;
  logic [1:0]         ocnt_r;
  logic               o_push;
  logic               o_pop;
  logic               wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= gos_pkg::RST_MODE;
      cfg_r.lr   <= gos_pkg::RST_LR;
      cfg_r.b1   <= gos_pkg::RST_B1;
      cfg_r.b2   <= gos_pkg::RST_B2;
      cfg_r.eps  <= gos_pkg::RST_EPS;
    end else if (wr) begin
      unique case (paddr[4:2])
        gos_pkg::REG_MODE: cfg_r.mode <= pwdata[1:0];
        gos_pkg::REG_LR:   cfg_r.lr   <= pwdata[23:0];
        gos_pkg::REG_B1:   cfg_r.b1   <= pwdata[23:0];
        gos_pkg::REG_B2:   cfg_r.b2   <= pwdata[23:0];
        gos_pkg::REG_EPS:  cfg_r.eps  <= pwdata[28:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      gos_pkg::REG_MODE: prdata = 32'(cfg_r.mode);
      gos_pkg::REG_LR:   prdata = 32'(cfg_r.lr);
      gos_pkg::REG_B1:   prdata = 32'(cfg_r.b1);
      gos_pkg::REG_B2:   prdata = 32'(cfg_r.b2);
      gos_pkg::REG_EPS:  prdata = 32'(cfg_r.eps);
      default:           prdata = 32'd0;
    endcase
  end

  gos_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .cfg_mode   (cfg_r.mode),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  gos_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = (ocnt_r != 2'd2);
  assign empty     = (ocnt_r == 2'd0);
  assign out_item  = oq_r[orp_r];
  assign o_push    = res_valid && res_ready;
  assign o_pop     = pop && !empty;

  always_ff @(posedge clk) begin
    if (o_push) begin
      oq_r[owp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (o_push) begin
        owp_r <= !owp_r;
      end
      if (o_pop) begin
        orp_r <= !orp_r;
      end
      ocnt_r <= ocnt_r + 2'(o_push) - 2'(o_pop);
    end
  end

endmodule

FILE: test/gradient_optimizer_step_checker.sv
`timescale 1ns / 1ps
// Checker that predicts each parameter update and compares it with the core's results.
module gradient_optimizer_step_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  gos_pkg::in_item_t  in_item,
  input  logic               empty,
  input  logic               pop,
  input  gos_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending,
  output int                 n_updates,
  output int                 n_flagged
);

  gos_pkg::mode_t mode_q;
  logic [23:0]    lr_q;
  logic [23:0]    b1_q;
  logic [23:0]    b2_q;
  logic [28:0]    eps_q;

  logic signed [31:0] first_mom [gos_pkg::STATE_DEPTH];
  logic [47:0]        second_mom [gos_pkg::STATE_DEPTH];

  gos_pkg::out_item_t expected_params[$];

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned trial;
    res = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = res | (64'd1 << i);
      if (trial * trial <= x) res = trial;
    end
    return res;
  endfunction

  function automatic longint saturate(longint x, ref logic flag);
    if (x > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic gos_pkg::out_item_t update_param(gos_pkg::in_item_t it);
    int                 idx;
    longint             p;
    longint             g;
    longint             x;
    longint             v;
    longint             lr;
    longint             b;
    longint             res;
    longint unsigned    mag;
    longint unsigned    gsq;
    longint unsigned    r;
    longint unsigned    d;
    longint unsigned    xm;
    longint unsigned    quo;
    logic [79:0]        mixv;
    logic [47:0]        s;
    logic               flag;
    gos_pkg::out_item_t o;
    idx = int'(it.param_index) % gos_pkg::STATE_DEPTH;
    p = it.param_value;
    g = it.gradient;
    lr = longint'(lr_q);
    x = g;
    flag = 1'b0;
    if (mode_q == gos_pkg::MODE_MOM || mode_q == gos_pkg::MODE_ADAM) begin
      b = longint'(b1_q);
      v = (b * longint'(first_mom[idx]) + ((64'sd1 <<< 24) - b) * g + (64'sd1 <<< 23)) >>> 24;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      first_mom[idx] = v[31:0];
      x = v;
    end
    if (mode_q == gos_pkg::MODE_RMS || mode_q == gos_pkg::MODE_ADAM) begin
      mag = (g < 0) ? longint'(-g) : longint'(g);
      gsq = (mag * mag + (64'd1 << 15)) >> 16;
      mixv = 80'(b2_q) * 80'(second_mom[idx]) + (80'd16777216 - 80'(b2_q)) * 80'(gsq)
             + 80'd8388608;
      s = mixv[71:24];
      second_mom[idx] = s;
      r = longint'(s) + longint'(eps_q);
      if (r > 64'hFFFF_FFFF_FFFF) r = 64'hFFFF_FFFF_FFFF;
      d = int_sqrt(r << 16);
      if (d == 0) begin
        res = p;
        flag = 1'b1;
      end else begin
        xm = (x < 0) ? longint'(-x) : longint'(x);
        quo = (longint'(lr) * xm) / d;
        res = (x < 0) ? p + longint'(quo) : p - longint'(quo);
        res = saturate(res, flag);
      end
    end else begin
      res = saturate(p - ((lr * x + (64'sd1 <<< 23)) >>> 24), flag);
    end
    o.new_param = res[31:0];
    o.flagged = flag;
    return o;
  endfunction

  always @(posedge clk) begin
    gos_pkg::out_item_t exp_item;
    int                 bad;
    if (!rst_n) begin
      mode_q <= gos_pkg::RST_MODE;
      lr_q <= gos_pkg::RST_LR;
      b1_q <= gos_pkg::RST_B1;
      b2_q <= gos_pkg::RST_B2;
      eps_q <= gos_pkg::RST_EPS;
      for (int i = 0; i < gos_pkg::STATE_DEPTH; i++) begin
        first_mom[i] = '0;
        second_mom[i] = '0;
      end
      expected_params.delete();
      errors <= 0;
      n_updates <= 0;
      n_flagged <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          gos_pkg::REG_MODE: mode_q <= pwdata[1:0];
          gos_pkg::REG_LR:   lr_q <= pwdata[23:0];
          gos_pkg::REG_B1:   b1_q <= pwdata[23:0];
          gos_pkg::REG_B2:   b2_q <= pwdata[23:0];
          gos_pkg::REG_EPS:  eps_q <= pwdata[28:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        expected_params.insert(expected_params.size(), update_param(in_item));
      end
      if (pop && !empty) begin
        bad = 0;
        n_updates <= n_updates + 1;
        if (out_item.flagged) n_flagged <= n_flagged + 1;
        if (expected_params.size() == 0) begin
          $display("%0t: unexpected transaction, actual new_param %h flagged %b",
                   $time, out_item.new_param, out_item.flagged);
          bad = bad + 1;
        end else begin
          exp_item = expected_params.pop_front();
          if (out_item.new_param !== exp_item.new_param) begin
            $display("%0t: new_param mismatch, expected %h actual %h",
                     $time, exp_item.new_param, out_item.new_param);
            bad = bad + 1;
          end
          if (out_item.flagged !== exp_item.flagged) begin
            $display("%0t: flagged mismatch, expected %b actual %b",
                     $time, exp_item.flagged, out_item.flagged);
            bad = bad + 1;
          end
        end
        errors <= errors + bad;
      end
    end
    pending <= expected_params.size();
  end

endmodule

FILE: test/gradient_optimizer_step_core_test.sv
`timescale 1ns / 1ps
// Testbench top that drives the optimizer step core and reports the verdict.
module gradient_optimizer_step_core_test;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 106;

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  gos_pkg::in_item_t  in_item;
  logic               empty;
  logic               pop;
  gos_pkg::out_item_t out_item;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int  errors;
  int  pending;
  int  n_updates;
  int  n_flagged;
  int  cycles;
  bit  quiet;

  gradient_optimizer_step_core DUT (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  gradient_optimizer_step_checker checker_i (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
    .errors(errors), .pending(pending), .n_updates(n_updates), .n_flagged(n_flagged)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        pop = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      pop = 1'b1;
    end
  end

  task automatic write_reg(input logic [2:0] reg_idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {reg_idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic settle;
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_config(input gos_pkg::mode_t m, input logic [23:0] lr,
                            input logic [23:0] b1, input logic [23:0] b2,
                            input logic [28:0] eps);
    settle();
    write_reg(gos_pkg::REG_MODE, 32'(m));
    write_reg(gos_pkg::REG_LR, 32'(lr));
    write_reg(gos_pkg::REG_B1, 32'(b1));
    write_reg(gos_pkg::REG_B2, 32'(b2));
    write_reg(gos_pkg::REG_EPS, 32'(eps));
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_update(input logic [11:0] idx, input logic [31:0] p, input logic [31:0] g);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    push = 1'b1;
    in_item.param_index = idx;
    in_item.param_value = p;
    in_item.gradient = g;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    push = 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4: return 32'($signed($urandom_range(0, 33554432)) - 16777216);
      5, 6: return 32'($signed($urandom_range(0, 1048576)) - 524288);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] pick_q24();
    case ($urandom_range(0, 5))
      0: return 24'd1;
      1: return 24'hFF_FFFF;
      default: return 24'($urandom_range(1, 16777215));
    endcase
  endfunction

  initial begin
    logic [28:0] eps;
    rst_n = 1'b0;
    push = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int m = 0; m < 4; m++) begin
      set_config(gos_pkg::mode_t'(m), 24'hFF_FFFF, 24'd1, 24'hFF_FFFF, 29'd0);
      send_update(12'd4095, 32'h0, 32'h0);
      send_update(12'd0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_update(12'd1, 32'h8000_0000, 32'h7FFF_FFFF);
      send_update(12'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_update(12'd0, 32'h8000_0000, 32'h8000_0000);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        set_config(gos_pkg::MODE_ADAM, 24'd1, 24'hFF_FFFF, 24'd1, 29'd429496729);
      end else begin
        case ($urandom_range(0, 3))
          0: eps = 29'd0;
          1: eps = 29'd429496729;
          default: eps = 29'($urandom_range(0, 429496729));
        endcase
        set_config(gos_pkg::mode_t'(ph % 4), pick_q24(), pick_q24(), pick_q24(), eps);
      end
      quiet = (ph == RANDOM_PHASES - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 9) < 7)
          send_update(12'($urandom_range(0, 15)), pick_value(), pick_value());
        else
          send_update(12'($urandom), pick_value(), pick_value());
      end
    end

    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("Ran %0d updates over four update rules and twelve register settings,", n_updates);
    $display("including extreme registers; %0d results were flagged.", n_flagged);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/gos_pkg.sv
hdl/gos_front.sv
hdl/gos_sqrt.sv
hdl/gos_div.sv
hdl/gos_back.sv
hdl/gradient_optimizer_step_core.sv
test/gradient_optimizer_step_checker.sv
test/gradient_optimizer_step_core_test.sv
